/* src/tlaf_pkg.sv */
// Package for the target lock acquisition machine: state codes, register map, defaults.
`timescale 1ns / 1ps

package tlaf_pkg;

  // Lock machine state codes
  typedef enum logic [2:0] {
    ST_UNLOCKED    = 3'd0,
    ST_SEARCHING   = 3'd1,
    ST_FOUND       = 3'd2,
    ST_VERIFYING   = 3'd3,
    ST_LOCKED      = 3'd4,
    ST_REVERIFYING = 3'd5,
    ST_LOST        = 3'd6,
    ST_RELOCKING   = 3'd7
  } lock_state_t;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 3;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LOCK_THRESHOLD = 3'd0,
    REG_DROP_THRESHOLD = 3'd1,
    REG_LOST_TIMEOUT   = 3'd2,
    REG_RELOCK_TIMEOUT = 3'd3
  } cfg_index_t;

  localparam int CONF_BITS = 16;
  localparam int CFG_DATA_BITS = 16;

  // Register reset values
  localparam logic [CFG_DATA_BITS-1:0] LOCK_THRESHOLD_RESET = 16'd32768;
  localparam logic [CFG_DATA_BITS-1:0] DROP_THRESHOLD_RESET = 16'd19661;
  localparam logic [CFG_DATA_BITS-1:0] LOST_TIMEOUT_RESET   = 16'd10;
  localparam logic [CFG_DATA_BITS-1:0] RELOCK_TIMEOUT_RESET = 16'd60;

  // Default widths of identifier and frame number
  localparam int ID_BITS_DEFAULT    = 32;
  localparam int FRAME_BITS_DEFAULT = 32;

  // Register file contents seen by the transition logic
  typedef struct packed {
    logic [CFG_DATA_BITS-1:0] lock_threshold;
    logic [CFG_DATA_BITS-1:0] drop_threshold;
    logic [CFG_DATA_BITS-1:0] lost_timeout;
    logic [CFG_DATA_BITS-1:0] relock_timeout;
  } cfg_t;

endpackage

/* src/target_lock_acquisition_fsm_unit.sv */
// Top level of the target lock acquisition machine: input stage, state/result register.
`timescale 1ns / 1ps

// Takes one candidate beat per clock and returns one result beat per candidate.
// A beat is captured in the input register, the transition logic works on it
// there, and the updated lock state and snapshot land in the state register,
// which is also the result register, once the result slot is free or being
// drained; the sustained rate is one beat per cycle while the result side
// keeps taking beats. The input register lets a new beat in while a result
// waits, if it is empty. Configuration writes take effect on the next clock
// and should be issued only while no beat is in flight; a clear request
// (func = 1) resets the tracking state but leaves the registers as written.
module target_lock_acquisition_fsm_unit #(
  parameter int ID_BITS    = tlaf_pkg::ID_BITS_DEFAULT,
  parameter int FRAME_BITS = tlaf_pkg::FRAME_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_wr_en,
  input  logic [tlaf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [tlaf_pkg::CFG_DATA_BITS-1:0] cfg_data,
  // candidate channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               func,
  input  logic                               cand_valid,
  input  logic [ID_BITS-1:0]                 cand_id,
  input  logic [tlaf_pkg::CONF_BITS-1:0]     cand_confidence,
  input  logic [FRAME_BITS-1:0]              frame_number,
  input  logic                               cand_reversed_z,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2:0]                         lock_state,
  output logic                               snapshot_valid,
  output logic [tlaf_pkg::CONF_BITS-1:0]     snapshot_confidence,
  output logic [FRAME_BITS-1:0]              snapshot_frame,
  output logic                               snapshot_reversed_z,
  output logic [ID_BITS-1:0]                 tracked_id,
  output logic [tlaf_pkg::CONF_BITS-1:0]     tracked_confidence
);

  tlaf_pkg::cfg_t cfg;

  // input register
  logic                           s1_valid;
  logic                           s1_func;
  logic                           s1_cand_valid;
  logic [ID_BITS-1:0]             s1_id;
  logic [tlaf_pkg::CONF_BITS-1:0] s1_conf;
  logic [FRAME_BITS-1:0]          s1_frame;
  logic                           s1_rz;

  // state register, doubling as result register
  tlaf_pkg::lock_state_t          state;
  logic [ID_BITS-1:0]             trk_id;
  logic [FRAME_BITS-1:0]          last_seen;
  logic [tlaf_pkg::CONF_BITS-1:0] last_conf;
  logic                           snap_valid;
  logic [tlaf_pkg::CONF_BITS-1:0] snap_conf;
  logic [FRAME_BITS-1:0]          snap_frame;
  logic                           snap_rz;

  tlaf_pkg::lock_state_t          state_next;
  logic [ID_BITS-1:0]             trk_id_next;
  logic [FRAME_BITS-1:0]          last_seen_next;
  logic [tlaf_pkg::CONF_BITS-1:0] last_conf_next;
  logic                           snap_valid_next;
  logic [tlaf_pkg::CONF_BITS-1:0] snap_conf_next;
  logic [FRAME_BITS-1:0]          snap_frame_next;
  logic                           snap_rz_next;

  logic advance;

  tlaf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Advance the held beat once the result slot is free or being drained
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Capture the incoming beat
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_func       <= func;
      s1_cand_valid <= cand_valid;
      s1_id         <= cand_id;
      s1_conf       <= cand_confidence;
      s1_frame      <= frame_number;
      s1_rz         <= cand_reversed_z;
    end
  end

  tlaf_next #(
    .ID_BITS    (ID_BITS),
    .FRAME_BITS (FRAME_BITS)
  ) u_next (
    .cfg             (cfg),
    .state           (state),
    .trk_id          (trk_id),
    .last_seen       (last_seen),
    .last_conf       (last_conf),
    .snap_valid      (snap_valid),
    .snap_conf       (snap_conf),
    .snap_frame      (snap_frame),
    .snap_rz         (snap_rz),
    .func            (s1_func),
    .cand_valid      (s1_cand_valid),
    .cand_id         (s1_id),
    .cand_confidence (s1_conf),
    .frame_number    (s1_frame),
    .cand_reversed_z (s1_rz),
    .state_next      (state_next),
    .trk_id_next     (trk_id_next),
    .last_seen_next  (last_seen_next),
    .last_conf_next  (last_conf_next),
    .snap_valid_next (snap_valid_next),
    .snap_conf_next  (snap_conf_next),
    .snap_frame_next (snap_frame_next),
    .snap_rz_next    (snap_rz_next)
  );

  // Update the state register on each processed beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tlaf_pkg::ST_UNLOCKED;
      trk_id     <= '0;
      last_seen  <= '0;
      last_conf  <= '0;
      snap_valid <= 1'b0;
      snap_conf  <= '0;
      snap_frame <= '0;
      snap_rz    <= 1'b0;
    end else if (advance) begin
      state      <= state_next;
      trk_id     <= trk_id_next;
      last_seen  <= last_seen_next;
      last_conf  <= last_conf_next;
      snap_valid <= snap_valid_next;
      snap_conf  <= snap_conf_next;
      snap_frame <= snap_frame_next;
      snap_rz    <= snap_rz_next;
    end
  end

  // Raise result valid per processed beat, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign lock_state          = state;
  assign snapshot_valid      = snap_valid;
  assign snapshot_confidence = snap_conf;
  assign snapshot_frame      = snap_frame;
  assign snapshot_reversed_z = snap_rz;
  assign tracked_id          = trk_id;
  assign tracked_confidence  = last_conf;

`ifndef SYNTHESIS
  // an invalid snapshot always carries zero confidence
  a_snap_conf_cleared: assert property (@(posedge clk) disable iff (rst)
    !snap_valid |-> (snap_conf == '0))
    else $error("invalid snapshot with nonzero confidence");

  // state moves only when a beat is processed
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state) && $stable(trk_id) && $stable(last_seen))
    else $error("state changed without a processed beat");

  // input is refused only when a beat is held and the result is stalled
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input refused without a stall");

  // a new result follows a processed beat
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result raised without a held beat");
`endif

endmodule

/* src/tlaf_cfg_regs.sv */
// Configuration register file of the target lock acquisition machine.
`timescale 1ns / 1ps

module tlaf_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [tlaf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [tlaf_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output tlaf_pkg::cfg_t                       cfg
);

  // Write the addressed register; drop writes beyond the map
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lock_threshold <= tlaf_pkg::LOCK_THRESHOLD_RESET;
      cfg.drop_threshold <= tlaf_pkg::DROP_THRESHOLD_RESET;
      cfg.lost_timeout   <= tlaf_pkg::LOST_TIMEOUT_RESET;
      cfg.relock_timeout <= tlaf_pkg::RELOCK_TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tlaf_pkg::REG_LOCK_THRESHOLD: cfg.lock_threshold <= cfg_data;
        tlaf_pkg::REG_DROP_THRESHOLD: cfg.drop_threshold <= cfg_data;
        tlaf_pkg::REG_LOST_TIMEOUT:   cfg.lost_timeout   <= cfg_data;
        tlaf_pkg::REG_RELOCK_TIMEOUT: cfg.relock_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* src/tlaf_next.sv */
// Transition logic: next lock state, tracking and snapshot values for one beat.
`timescale 1ns / 1ps

module tlaf_next #(
  parameter int ID_BITS    = tlaf_pkg::ID_BITS_DEFAULT,
  parameter int FRAME_BITS = tlaf_pkg::FRAME_BITS_DEFAULT
) (
  input  tlaf_pkg::cfg_t                    cfg,
  // current state
  input  tlaf_pkg::lock_state_t             state,
  input  logic [ID_BITS-1:0]                trk_id,
  input  logic [FRAME_BITS-1:0]             last_seen,
  input  logic [tlaf_pkg::CONF_BITS-1:0]    last_conf,
  input  logic                              snap_valid,
  input  logic [tlaf_pkg::CONF_BITS-1:0]    snap_conf,
  input  logic [FRAME_BITS-1:0]             snap_frame,
  input  logic                              snap_rz,
  // item
  input  logic                              func,
  input  logic                              cand_valid,
  input  logic [ID_BITS-1:0]                cand_id,
  input  logic [tlaf_pkg::CONF_BITS-1:0]    cand_confidence,
  input  logic [FRAME_BITS-1:0]             frame_number,
  input  logic                              cand_reversed_z,
  // next state
  output tlaf_pkg::lock_state_t             state_next,
  output logic [ID_BITS-1:0]                trk_id_next,
  output logic [FRAME_BITS-1:0]             last_seen_next,
  output logic [tlaf_pkg::CONF_BITS-1:0]    last_conf_next,
  output logic                              snap_valid_next,
  output logic [tlaf_pkg::CONF_BITS-1:0]    snap_conf_next,
  output logic [FRAME_BITS-1:0]             snap_frame_next,
  output logic                              snap_rz_next
);

  logic                  has;
  logic                  same_id;
  logic                  conf_lock;
  logic                  conf_drop;
  logic [FRAME_BITS-1:0] since;
  logic                  lost_expired;
  logic                  relock_expired;
  tlaf_pkg::lock_state_t fsm_next;
  logic                  match;

  // Decode the candidate against the tracked target and thresholds
  assign has            = cand_valid && (cand_id != '0);
  assign same_id        = has && (cand_id == trk_id);
  assign conf_lock      = cand_confidence >= cfg.lock_threshold;
  assign conf_drop      = cand_confidence < cfg.drop_threshold;
  assign since          = frame_number - last_seen;
  assign lost_expired   = since > FRAME_BITS'(cfg.lost_timeout);
  assign relock_expired = since > FRAME_BITS'(cfg.relock_timeout);

  // Next lock state
  always_comb begin
    fsm_next = state;
    unique case (state)
      tlaf_pkg::ST_UNLOCKED: begin
        if (has) fsm_next = tlaf_pkg::ST_SEARCHING;
      end
      tlaf_pkg::ST_SEARCHING: begin
        fsm_next = has ? tlaf_pkg::ST_FOUND : tlaf_pkg::ST_UNLOCKED;
      end
      tlaf_pkg::ST_FOUND: begin
        fsm_next = same_id ? tlaf_pkg::ST_VERIFYING : tlaf_pkg::ST_SEARCHING;
      end
      tlaf_pkg::ST_VERIFYING: begin
        fsm_next = (same_id && conf_lock) ? tlaf_pkg::ST_LOCKED : tlaf_pkg::ST_SEARCHING;
      end
      tlaf_pkg::ST_LOCKED: begin
        if (!same_id) fsm_next = tlaf_pkg::ST_LOST;
        else if (!conf_lock) fsm_next = tlaf_pkg::ST_REVERIFYING;
      end
      tlaf_pkg::ST_REVERIFYING: begin
        if (!same_id) fsm_next = tlaf_pkg::ST_LOST;
        else if (conf_lock) fsm_next = tlaf_pkg::ST_LOCKED;
        else if (conf_drop) fsm_next = tlaf_pkg::ST_RELOCKING;
      end
      tlaf_pkg::ST_LOST: begin
        if (same_id) fsm_next = tlaf_pkg::ST_RELOCKING;
        else if (lost_expired) fsm_next = tlaf_pkg::ST_SEARCHING;
      end
      tlaf_pkg::ST_RELOCKING: begin
        if (same_id && conf_lock) fsm_next = tlaf_pkg::ST_LOCKED;
        else if (relock_expired) fsm_next = tlaf_pkg::ST_SEARCHING;
      end
      default: fsm_next = state;
    endcase
  end

  // Tracking and snapshot outputs; a clear request overrides everything
  always_comb begin
    state_next      = fsm_next;
    trk_id_next     = trk_id;
    last_seen_next  = last_seen;
    last_conf_next  = last_conf;
    snap_valid_next = snap_valid;
    snap_conf_next  = snap_conf;
    snap_frame_next = snap_frame;
    snap_rz_next    = snap_rz;

    // take the new target on leaving searching
    if (state == tlaf_pkg::ST_SEARCHING && has) trk_id_next = cand_id;

    // match against the identifier as updated above
    match = has && (cand_id == trk_id_next);
    if (match) begin
      last_seen_next  = frame_number;
      last_conf_next  = cand_confidence;
      snap_frame_next = frame_number;
      snap_conf_next  = cand_confidence;
      snap_rz_next    = cand_reversed_z;
      snap_valid_next = 1'b1;
    end else if (fsm_next == tlaf_pkg::ST_SEARCHING || fsm_next == tlaf_pkg::ST_UNLOCKED) begin
      snap_valid_next = 1'b0;
      snap_conf_next  = '0;
    end

    if (func) begin
      state_next      = tlaf_pkg::ST_UNLOCKED;
      trk_id_next     = '0;
      last_seen_next  = '0;
      last_conf_next  = '0;
      snap_valid_next = 1'b0;
      snap_conf_next  = '0;
      snap_frame_next = '0;
      snap_rz_next    = 1'b0;
    end
  end

endmodule
